FILE: src/via_pkg.sv
`timescale 1ns / 1ps

package via_pkg;

   // request kinds carried in tuser
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } via_op_type;

   // register map
   typedef enum logic [3:0] {
      REG_ORB    = 4'h0,
      REG_ORA    = 4'h1,
      REG_DDRB   = 4'h2,
      REG_DDRA   = 4'h3,
      REG_T1CL   = 4'h4,
      REG_T1CH   = 4'h5,
      REG_T1LL   = 4'h6,
      REG_T1LH   = 4'h7,
      REG_T2CL   = 4'h8,
      REG_T2CH   = 4'h9,
      REG_SR     = 4'hA,
      REG_ACR    = 4'hB,
      REG_PCR    = 4'hC,
      REG_IFR    = 4'hD,
      REG_IER    = 4'hE,
      REG_ORA_NH = 4'hF
   } via_reg_type;

   // interrupt flag bit positions
   localparam int FLAG_T1 = 6;
   localparam int FLAG_T2 = 5;
   localparam int FLAG_SR = 2;

   // shift register modes, acr[4:2]
   localparam logic [2:0] SR_IN_DIV   = 3'b001;
   localparam logic [2:0] SR_IN_SYS   = 3'b010;
   localparam logic [2:0] SR_FREE_DIV = 3'b100;
   localparam logic [2:0] SR_OUT_DIV  = 3'b101;
   localparam logic [2:0] SR_OUT_SYS  = 3'b110;
   localparam logic [3:0] SR_BITS     = 4'd8;

   // ca2 control, pcr[3:1], and cb2 control, pcr[7:5]
   localparam logic [2:0] CTL_HANDSHAKE = 3'b100;
   localparam logic [2:0] CTL_PULSE     = 3'b101;
   localparam logic [2:0] CTL_LOW       = 3'b110;

   // one request
   typedef struct packed {
      via_op_type  op;
      logic [3:0]  reg_addr;
      logic [7:0]  write_data;
      logic        comparator_in;
      logic [7:0]  alt_port_a;
   } via_req_type;

   // one response
   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
      logic [7:0] port_a_out;
      logic [7:0] port_b_out;
      logic       ca2_level;
      logic       cb2_handshake;
      logic       cb2_shift;
      logic       pb7_timer;
   } via_rsp_type;

   // architectural state of the adapter
   typedef struct packed {
      logic [7:0]  pa;
      logic [7:0]  pb;
      logic [7:0]  ddra;
      logic [7:0]  ddrb;
      logic [15:0] t1_cnt;
      logic [7:0]  t1_lo;
      logic [7:0]  t1_hi;
      logic        t1_run;
      logic        t1_arm;
      logic        t1_pb7;
      logic [15:0] t2_cnt;
      logic [7:0]  t2_lo;
      logic        t2_run;
      logic        t2_arm;
      logic [7:0]  sr;
      logic [3:0]  sr_cnt;
      logic [7:0]  sr_div;
      logic        sr_phase;
      logic [7:0]  acr;
      logic [7:0]  pcr;
      logic [6:0]  ifr;
      logic [6:0]  ier;
      logic        ca2;
      logic        cb2_hs;
      logic        cb2_sh;
   } via_state_type;

   localparam via_state_type VIA_STATE_RESET = '{
      pa: 8'h00, pb: 8'h00, ddra: 8'h00, ddrb: 8'h00,
      t1_cnt: 16'h0000, t1_lo: 8'h00, t1_hi: 8'h00,
      t1_run: 1'b0, t1_arm: 1'b0, t1_pb7: 1'b1,
      t2_cnt: 16'h0000, t2_lo: 8'h00, t2_run: 1'b0, t2_arm: 1'b0,
      sr: 8'h00, sr_cnt: SR_BITS, sr_div: 8'h00, sr_phase: 1'b0,
      acr: 8'h00, pcr: 8'h00, ifr: 7'h00, ier: 7'h00,
      ca2: 1'b1, cb2_hs: 1'b1, cb2_sh: 1'b0
   };

endpackage

FILE: src/versatile_interface_adapter_top.sv
`timescale 1ns / 1ps

// 6522-style interface adapter on a request/response stream. Each request
// is a register read, a register write, one clock tick or a no-op (kind in
// req_tuser); each request yields exactly one response carrying the read
// byte and the port, handshake, timer and interrupt lines after that
// request. One request is taken every cycle while no response is held off; a
// response passes from the input register, where its request waits, through
// the state update into the response register. The rate is set by the
// update of the adapter state registers, which every request reads and
// writes. While a response is held off, the input register fills and
// req_tready drops until the response is taken.
module versatile_interface_adapter_top import via_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] reg_addr, [11:4] write_data, [12] comparator_in, [20:13] alt_port_a,
   // [23:21] zero
   input  logic [23:0] req_tdata,
   // [1:0] op
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data, [8] irq, [16:9] port_a_out, [24:17] port_b_out,
   // [25] ca2_level, [26] cb2_handshake, [27] cb2_shift, [28] pb7_timer, [31:29] zero
   output logic [31:0] rsp_tdata
);

   via_req_type   req_item;
   via_req_type   stage_item;
   logic          stage_valid;
   logic          take;
   via_state_type state_ff, state_in;
   via_rsp_type   rsp_in, rsp_ff;
   logic          rsp_valid_ff, rsp_valid_in;

   // unpack the request
   assign req_item.op            = via_op_type'(req_tuser);
   assign req_item.reg_addr      = req_tdata[3:0];
   assign req_item.write_data    = req_tdata[11:4];
   assign req_item.comparator_in = req_tdata[12];
   assign req_item.alt_port_a    = req_tdata[20:13];

   via_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_take  (take),
      .out_item  (stage_item)
   );

   via_core u_core (
      .state_cur  (state_ff),
      .req_item   (stage_item),
      .state_next (state_in),
      .rsp_item   (rsp_in)
   );

   // process the staged request when the response register can take it
   assign take         = stage_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_tready);

   // adapter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= VIA_STATE_RESET;
      end else if (take) begin
         state_ff <= state_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   // pack the response, read_data in the lowest bits
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.pb7_timer, rsp_ff.cb2_shift, rsp_ff.cb2_handshake,
                        rsp_ff.ca2_level, rsp_ff.port_b_out, rsp_ff.port_a_out,
                        rsp_ff.irq, rsp_ff.read_data};

endmodule

FILE: src/via_in_stage.sv
`timescale 1ns / 1ps

module via_in_stage import via_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  via_req_type in_item,
   output logic        out_valid,
   input  logic        out_take,
   output via_req_type out_item
);

   logic        valid_ff, valid_in;
   via_req_type item_ff;

   // stage frees up in the same cycle its request is consumed
   assign in_ready = !valid_ff || out_take;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: src/via_core.sv
`timescale 1ns / 1ps

module via_core import via_pkg::*; (
   input  via_state_type state_cur,
   input  via_req_type   req_item,
   output via_state_type state_next,
   output via_rsp_type   rsp_item
);

   logic [7:0]  read_val;
   logic        div_tick;
   logic [7:0]  port_a_view;
   logic        irq_cur;
   logic [15:0] t1_dec;
   logic [15:0] t2_dec;
   logic [7:0]  div_dec;

   assign port_a_view = (state_cur.pb[4:3] == 2'b01) ? req_item.alt_port_a : state_cur.pa;
   assign irq_cur     = |(state_cur.ifr & state_cur.ier);
   assign t1_dec      = state_cur.t1_cnt - 16'd1;
   assign t2_dec      = state_cur.t2_cnt - 16'd1;
   assign div_dec     = state_cur.sr_div - 8'd1;

   // next state and read data for one request
   always_comb begin
      state_next = state_cur;
      read_val   = 8'h00;
      div_tick   = 1'b0;
      case (req_item.op)
         OP_READ: begin
            case (req_item.reg_addr)
               REG_ORB: begin
                  if (state_cur.acr[7]) begin
                     read_val = {state_cur.t1_pb7, state_cur.pb[6], req_item.comparator_in,
                                 state_cur.pb[4:0]};
                  end else begin
                     read_val = {state_cur.pb[7:6], req_item.comparator_in, state_cur.pb[4:0]};
                  end
               end
               REG_ORA: begin
                  if (state_cur.pcr[3:1] == CTL_HANDSHAKE) begin
                     state_next.ca2 = 1'b0;
                  end
                  read_val = port_a_view;
               end
               REG_ORA_NH: read_val = port_a_view;
               REG_DDRB:   read_val = state_cur.ddrb;
               REG_DDRA:   read_val = state_cur.ddra;
               REG_T1CL: begin
                  read_val                  = state_cur.t1_cnt[7:0];
                  state_next.t1_run         = 1'b0;
                  state_next.t1_arm         = 1'b0;
                  state_next.t1_pb7         = 1'b1;
                  state_next.ifr[FLAG_T1]   = 1'b0;
               end
               REG_T1CH: read_val = state_cur.t1_cnt[15:8];
               REG_T1LL: read_val = state_cur.t1_lo;
               REG_T1LH: read_val = state_cur.t1_hi;
               REG_T2CL: begin
                  read_val                  = state_cur.t2_cnt[7:0];
                  state_next.t2_run         = 1'b0;
                  state_next.t2_arm         = 1'b0;
                  state_next.ifr[FLAG_T2]   = 1'b0;
               end
               REG_T2CH: read_val = state_cur.t2_cnt[15:8];
               REG_SR: begin
                  read_val                  = state_cur.sr;
                  state_next.sr_cnt         = 4'd0;
                  state_next.sr_phase       = 1'b1;
                  state_next.ifr[FLAG_SR]   = 1'b0;
               end
               REG_ACR: read_val = state_cur.acr;
               REG_PCR: read_val = state_cur.pcr;
               REG_IFR: read_val = {irq_cur, state_cur.ifr};
               default: read_val = {1'b1, state_cur.ier};
            endcase
         end
         OP_WRITE: begin
            case (req_item.reg_addr)
               REG_ORB: begin
                  state_next.pb = req_item.write_data;
                  if (state_cur.pcr[7:5] == CTL_HANDSHAKE) begin
                     state_next.cb2_hs = 1'b0;
                  end
               end
               REG_ORA: begin
                  if (state_cur.pcr[3:1] == CTL_HANDSHAKE) begin
                     state_next.ca2 = 1'b0;
                  end
                  state_next.pa = req_item.write_data;
               end
               REG_ORA_NH: state_next.pa   = req_item.write_data;
               REG_DDRB:   state_next.ddrb = req_item.write_data;
               REG_DDRA:   state_next.ddra = req_item.write_data;
               REG_T1CL:   state_next.t1_lo = req_item.write_data;
               REG_T1CH: begin
                  state_next.t1_hi          = req_item.write_data;
                  state_next.t1_cnt         = {req_item.write_data, state_cur.t1_lo};
                  state_next.t1_run         = 1'b1;
                  state_next.t1_arm         = 1'b1;
                  state_next.t1_pb7         = 1'b0;
                  state_next.ifr[FLAG_T1]   = 1'b0;
               end
               REG_T1LL: state_next.t1_lo = req_item.write_data;
               REG_T1LH: state_next.t1_hi = req_item.write_data;
               REG_T2CL: state_next.t2_lo = req_item.write_data;
               REG_T2CH: begin
                  state_next.t2_cnt         = {req_item.write_data, state_cur.t2_lo};
                  state_next.t2_run         = 1'b1;
                  state_next.t2_arm         = 1'b1;
                  state_next.ifr[FLAG_T2]   = 1'b0;
               end
               REG_SR: begin
                  state_next.sr             = req_item.write_data;
                  state_next.sr_cnt         = 4'd0;
                  state_next.sr_phase       = 1'b1;
                  state_next.ifr[FLAG_SR]   = 1'b0;
               end
               REG_ACR: state_next.acr = req_item.write_data;
               REG_PCR: begin
                  state_next.pcr    = req_item.write_data;
                  state_next.ca2    = (req_item.write_data[3:1] != CTL_LOW);
                  state_next.cb2_hs = (req_item.write_data[7:5] != CTL_LOW);
               end
               REG_IFR: state_next.ifr = state_cur.ifr & ~req_item.write_data[6:0];
               default: begin
                  if (req_item.write_data[7]) begin
                     state_next.ier = state_cur.ier | req_item.write_data[6:0];
                  end else begin
                     state_next.ier = state_cur.ier & ~req_item.write_data[6:0];
                  end
               end
            endcase
         end
         OP_TICK: begin
            // timer 1, one-shot or free-run with pb7 toggle
            if (state_cur.t1_run) begin
               state_next.t1_cnt = t1_dec;
               if (state_cur.t1_cnt == 16'h0000) begin
                  if (state_cur.acr[6]) begin
                     state_next.ifr[FLAG_T1] = 1'b1;
                     state_next.t1_pb7       = ~state_cur.t1_pb7;
                     state_next.t1_cnt       = {state_cur.t1_hi, state_cur.t1_lo};
                  end else if (state_cur.t1_arm) begin
                     state_next.ifr[FLAG_T1] = 1'b1;
                     state_next.t1_pb7       = 1'b1;
                     state_next.t1_arm       = 1'b0;
                  end
               end
            end
            // timer 2, held while pulse counting is selected
            if (state_cur.t2_run && !state_cur.acr[5]) begin
               state_next.t2_cnt = t2_dec;
               if (state_cur.t2_cnt == 16'h0000 && state_cur.t2_arm) begin
                  state_next.ifr[FLAG_T2] = 1'b1;
                  state_next.t2_arm       = 1'b0;
               end
            end
            // shift clock divider, shifts on every other underflow
            state_next.sr_div = div_dec;
            if (state_cur.sr_div == 8'h00) begin
               state_next.sr_div   = state_cur.t2_lo;
               div_tick            = state_cur.sr_phase;
               state_next.sr_phase = ~state_cur.sr_phase;
            end
            // shift register
            if (state_cur.sr_cnt < SR_BITS) begin
               case (state_cur.acr[4:2])
                  SR_IN_DIV: begin
                     if (div_tick) begin
                        state_next.sr     = {state_cur.sr[6:0], 1'b0};
                        state_next.sr_cnt = state_cur.sr_cnt + 4'd1;
                     end
                  end
                  SR_IN_SYS: begin
                     state_next.sr     = {state_cur.sr[6:0], 1'b0};
                     state_next.sr_cnt = state_cur.sr_cnt + 4'd1;
                  end
                  SR_FREE_DIV: begin
                     if (div_tick) begin
                        state_next.cb2_sh = state_cur.sr[7];
                        state_next.sr     = {state_cur.sr[6:0], state_cur.sr[7]};
                     end
                  end
                  SR_OUT_DIV: begin
                     if (div_tick) begin
                        state_next.cb2_sh = state_cur.sr[7];
                        state_next.sr     = {state_cur.sr[6:0], state_cur.sr[7]};
                        state_next.sr_cnt = state_cur.sr_cnt + 4'd1;
                     end
                  end
                  SR_OUT_SYS: begin
                     state_next.cb2_sh = state_cur.sr[7];
                     state_next.sr     = {state_cur.sr[6:0], state_cur.sr[7]};
                     state_next.sr_cnt = state_cur.sr_cnt + 4'd1;
                  end
                  default: ;
               endcase
               if (state_next.sr_cnt == SR_BITS) begin
                  state_next.ifr[FLAG_SR] = 1'b1;
               end
            end
            // pulse modes drive the line high on every tick
            if (state_cur.pcr[3:1] == CTL_PULSE) begin
               state_next.ca2 = 1'b1;
            end
            if (state_cur.pcr[7:5] == CTL_PULSE) begin
               state_next.cb2_hs = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // response fields from the updated state
   assign rsp_item.read_data     = read_val;
   assign rsp_item.irq           = |(state_next.ifr & state_next.ier);
   assign rsp_item.port_a_out    = state_next.pa;
   assign rsp_item.port_b_out    = state_next.pb;
   assign rsp_item.ca2_level     = state_next.ca2;
   assign rsp_item.cb2_handshake = state_next.cb2_hs;
   assign rsp_item.cb2_shift     = state_next.cb2_sh;
   assign rsp_item.pb7_timer     = state_next.t1_pb7;

endmodule

FILE: src/via_checker.sv
`timescale 1ns / 1ps

module via_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] pending_ff, pending_in;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // requests accepted but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_acc && rsp_acc) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // no response without an outstanding request
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 2'd0)
      else $error("response without request");

   // input register plus response register hold at most two requests
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("too many requests in flight");

   // padding bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:29] == 3'b000)
      else $error("response padding not zero");

   // nothing pending out of reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind versatile_interface_adapter_top via_checker u_via_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import via_pkg::*;

   localparam int NUM_ITEMS    = 1450;
   localparam int NUM_DIRECTED = 25;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int LIMIT_CYCLES = 200000;

   // one row of the directed table
   typedef struct {
      via_op_type  op;
      via_reg_type addr;
      logic [7:0]  data;
      logic        cmp;
      logic [7:0]  alt;
      bit          typed;
      logic [7:0]  rd;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // [3:0] reg_addr, [11:4] write_data, [12] comparator_in, [20:13] alt_port_a,
   // [23:21] zero
   logic [23:0] req_tdata;
   // [1:0] op
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // [7:0] read_data, [8] irq, [16:9] port_a_out, [24:17] port_b_out,
   // [25] ca2_level, [26] cb2_handshake, [27] cb2_shift, [28] pb7_timer, [31:29] zero
   logic [31:0] rsp_tdata;

   // read byte typed into the table for the request on the bus
   bit          row_typed;
   logic [7:0]  row_rd;

   bit          no_idle      = 1'b0;
   bit          hold_started = 1'b0;
   bit          hold_done    = 1'b0;
   int          items_sent   = 0;
   int          mismatch_count = 0;
   int          cycle_count  = 0;

   via_rsp_type rsp_expected [$];

   // predicted adapter state, at its reset values
   logic [7:0]  ora_q       = 8'h00;
   logic [7:0]  orb_q       = 8'h00;
   logic [7:0]  ddra_q      = 8'h00;
   logic [7:0]  ddrb_q      = 8'h00;
   logic [15:0] t1_count    = 16'h0000;
   logic [7:0]  t1_latch_lo = 8'h00;
   logic [7:0]  t1_latch_hi = 8'h00;
   logic        t1_running  = 1'b0;
   logic        t1_armed    = 1'b0;
   logic        t1_pb7      = 1'b1;
   logic [15:0] t2_count    = 16'h0000;
   logic [7:0]  t2_latch_lo = 8'h00;
   logic        t2_running  = 1'b0;
   logic        t2_armed    = 1'b0;
   logic [7:0]  sr_data     = 8'h00;
   logic [3:0]  sr_bits     = SR_BITS;
   logic [7:0]  sr_div      = 8'h00;
   logic        sr_phase    = 1'b0;
   logic [7:0]  acr_q       = 8'h00;
   logic [7:0]  pcr_q       = 8'h00;
   logic [6:0]  ifr_q       = 7'h00;
   logic [6:0]  ier_q       = 7'h00;
   logic        ca2_q       = 1'b1;
   logic        cb2_hs_q    = 1'b1;
   logic        cb2_sh_q    = 1'b0;

   // directed requests: reset values, extremes, every request kind
   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{OP_READ,  REG_ORB,    8'h00, 1'b0, 8'h00, 1'b1, 8'h00},
      '{OP_READ,  REG_ORB,    8'hff, 1'b1, 8'hff, 1'b1, 8'h20},
      '{OP_READ,  REG_IER,    8'h00, 1'b0, 8'h00, 1'b1, 8'h80},
      '{OP_READ,  REG_IFR,    8'h00, 1'b0, 8'h00, 1'b1, 8'h00},
      '{OP_NONE,  REG_ORA_NH, 8'hff, 1'b1, 8'hff, 1'b1, 8'h00},
      '{OP_WRITE, REG_IER,    8'hff, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_WRITE, REG_ORB,    8'h08, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_READ,  REG_ORA,    8'h00, 1'b0, 8'ha5, 1'b1, 8'ha5},
      '{OP_READ,  REG_ORA_NH, 8'h00, 1'b1, 8'h5a, 1'b1, 8'h5a},
      '{OP_WRITE, REG_ORB,    8'hff, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_READ,  REG_ORB,    8'h00, 1'b0, 8'h00, 1'b1, 8'hdf},
      '{OP_WRITE, REG_DDRA,   8'hff, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_READ,  REG_DDRA,   8'h00, 1'b0, 8'h00, 1'b1, 8'hff},
      '{OP_WRITE, REG_T1LL,   8'h01, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_WRITE, REG_T1CH,   8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_TICK,  REG_ORB,    8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_TICK,  REG_ORB,    8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_READ,  REG_IFR,    8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_READ,  REG_T1CL,   8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_WRITE, REG_ACR,    8'hff, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_WRITE, REG_PCR,    8'h88, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_WRITE, REG_ORA,    8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_WRITE, REG_PCR,    8'hcc, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_WRITE, REG_SR,     8'hff, 1'b0, 8'h00, 1'b0, 8'h00},
      '{OP_WRITE, REG_ACR,    8'h18, 1'b0, 8'h00, 1'b0, 8'h00}
   };

   versatile_interface_adapter_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // one request applied to the predicted state
   task automatic adapter_step(input via_op_type op, input logic [3:0] addr,
                               input logic [7:0] wdata, input logic cmp,
                               input logic [7:0] alt, output via_rsp_type rsp);
      logic [7:0] rd;
      logic       div_tick;
      rd = 8'h00;
      div_tick = 1'b0;
      case (op)
         OP_READ: begin
            case (via_reg_type'(addr))
               REG_ORB: begin
                  rd = orb_q;
                  rd[5] = cmp;
                  if (acr_q[7]) rd[7] = t1_pb7;
               end
               REG_ORA, REG_ORA_NH: begin
                  // only the handshaking alias drops ca2
                  if (addr == REG_ORA && pcr_q[3:1] == CTL_HANDSHAKE) ca2_q = 1'b0;
                  rd = (orb_q[4:3] == 2'b01) ? alt : ora_q;
               end
               REG_DDRB: rd = ddrb_q;
               REG_DDRA: rd = ddra_q;
               REG_T1CL: begin
                  rd = t1_count[7:0];
                  t1_running = 1'b0;
                  t1_armed = 1'b0;
                  t1_pb7 = 1'b1;
                  ifr_q[FLAG_T1] = 1'b0;
               end
               REG_T1CH: rd = t1_count[15:8];
               REG_T1LL: rd = t1_latch_lo;
               REG_T1LH: rd = t1_latch_hi;
               REG_T2CL: begin
                  rd = t2_count[7:0];
                  t2_running = 1'b0;
                  t2_armed = 1'b0;
                  ifr_q[FLAG_T2] = 1'b0;
               end
               REG_T2CH: rd = t2_count[15:8];
               REG_SR: begin
                  rd = sr_data;
                  sr_bits = 4'd0;
                  sr_phase = 1'b1;
                  ifr_q[FLAG_SR] = 1'b0;
               end
               REG_ACR: rd = acr_q;
               REG_PCR: rd = pcr_q;
               REG_IFR: rd = {|(ifr_q & ier_q), ifr_q};
               default: rd = {1'b1, ier_q};
            endcase
         end
         OP_WRITE: begin
            case (via_reg_type'(addr))
               REG_ORB: begin
                  orb_q = wdata;
                  if (pcr_q[7:5] == CTL_HANDSHAKE) cb2_hs_q = 1'b0;
               end
               REG_ORA: begin
                  if (pcr_q[3:1] == CTL_HANDSHAKE) ca2_q = 1'b0;
                  ora_q = wdata;
               end
               REG_ORA_NH: ora_q = wdata;
               REG_DDRB: ddrb_q = wdata;
               REG_DDRA: ddra_q = wdata;
               REG_T1CL, REG_T1LL: t1_latch_lo = wdata;
               REG_T1CH: begin
                  t1_latch_hi = wdata;
                  t1_count = {wdata, t1_latch_lo};
                  t1_running = 1'b1;
                  t1_armed = 1'b1;
                  t1_pb7 = 1'b0;
                  ifr_q[FLAG_T1] = 1'b0;
               end
               REG_T1LH: t1_latch_hi = wdata;
               REG_T2CL: t2_latch_lo = wdata;
               REG_T2CH: begin
                  t2_count = {wdata, t2_latch_lo};
                  t2_running = 1'b1;
                  t2_armed = 1'b1;
                  ifr_q[FLAG_T2] = 1'b0;
               end
               REG_SR: begin
                  sr_data = wdata;
                  sr_bits = 4'd0;
                  sr_phase = 1'b1;
                  ifr_q[FLAG_SR] = 1'b0;
               end
               REG_ACR: acr_q = wdata;
               REG_PCR: begin
                  pcr_q = wdata;
                  ca2_q = (wdata[3:1] != CTL_LOW);
                  cb2_hs_q = (wdata[7:5] != CTL_LOW);
               end
               REG_IFR: ifr_q = ifr_q & ~wdata[6:0];
               default: begin
                  // bit 7 chooses set or clear of the enable bits
                  if (wdata[7]) ier_q = ier_q | wdata[6:0];
                  else ier_q = ier_q & ~wdata[6:0];
               end
            endcase
         end
         OP_TICK: begin
            // timer 1, one-shot or free-running with pb7 toggle
            if (t1_running) begin
               t1_count = t1_count - 16'd1;
               if (t1_count == 16'hffff) begin
                  if (acr_q[6]) begin
                     ifr_q[FLAG_T1] = 1'b1;
                     t1_pb7 = ~t1_pb7;
                     t1_count = {t1_latch_hi, t1_latch_lo};
                  end else if (t1_armed) begin
                     ifr_q[FLAG_T1] = 1'b1;
                     t1_pb7 = 1'b1;
                     t1_armed = 1'b0;
                  end
               end
            end
            // timer 2 holds while pulse counting is selected
            if (t2_running && !acr_q[5]) begin
               t2_count = t2_count - 16'd1;
               if (t2_count == 16'hffff && t2_armed) begin
                  ifr_q[FLAG_T2] = 1'b1;
                  t2_armed = 1'b0;
               end
            end
            // shift clock divider, reloaded from the timer 2 low latch
            sr_div = sr_div - 8'd1;
            if (sr_div == 8'hff) begin
               sr_div = t2_latch_lo;
               div_tick = sr_phase;
               sr_phase = ~sr_phase;
            end
            if (sr_bits < SR_BITS) begin
               case (acr_q[4:2])
                  SR_IN_DIV: begin
                     if (div_tick) begin
                        sr_data = sr_data << 1;
                        sr_bits = sr_bits + 4'd1;
                     end
                  end
                  SR_IN_SYS: begin
                     sr_data = sr_data << 1;
                     sr_bits = sr_bits + 4'd1;
                  end
                  SR_FREE_DIV: begin
                     if (div_tick) begin
                        cb2_sh_q = sr_data[7];
                        sr_data = {sr_data[6:0], sr_data[7]};
                     end
                  end
                  SR_OUT_DIV: begin
                     if (div_tick) begin
                        cb2_sh_q = sr_data[7];
                        sr_data = {sr_data[6:0], sr_data[7]};
                        sr_bits = sr_bits + 4'd1;
                     end
                  end
                  SR_OUT_SYS: begin
                     cb2_sh_q = sr_data[7];
                     sr_data = {sr_data[6:0], sr_data[7]};
                     sr_bits = sr_bits + 4'd1;
                  end
                  default: ;
               endcase
               if (sr_bits == SR_BITS) ifr_q[FLAG_SR] = 1'b1;
            end
            // pulse modes drive the line high on every tick
            if (pcr_q[3:1] == CTL_PULSE) ca2_q = 1'b1;
            if (pcr_q[7:5] == CTL_PULSE) cb2_hs_q = 1'b1;
         end
         default: ;
      endcase
      rsp.read_data     = rd;
      rsp.irq           = |(ifr_q & ier_q);
      rsp.port_a_out    = ora_q;
      rsp.port_b_out    = orb_q;
      rsp.ca2_level     = ca2_q;
      rsp.cb2_handshake = cb2_hs_q;
      rsp.cb2_shift     = cb2_sh_q;
      rsp.pb7_timer     = t1_pb7;
   endtask

   task automatic check_field(input string name, input logic [7:0] expv,
                              input logic [7:0] actv);
      if (actv !== expv) begin
         $display("%0t: %s mismatch, expected %02h, actual %02h",
                  $time, name, expv, actv);
         mismatch_count++;
      end
   endtask

   // offer one request, sometimes with a random gap before it
   task automatic send_request(input via_op_type op, input logic [3:0] addr,
                               input logic [7:0] data, input logic cmp,
                               input logic [7:0] alt, input bit typed,
                               input logic [7:0] rd);
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, alt, cmp, data, addr};
      row_typed  <= typed;
      row_rd     <= rd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op != OP_NONE) items_sent++;
   endtask

   task automatic send_plain(input via_op_type op, input logic [3:0] addr,
                             input logic [7:0] data);
      logic       cmp;
      logic [7:0] alt;
      cmp = 1'($urandom);
      alt = 8'($urandom);
      send_request(op, addr, data, cmp, alt, 1'b0, 8'h00);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_plain(OP_TICK, 4'($urandom), 8'($urandom));
   endtask

   // one random request, timer values mostly short so they expire
   task automatic send_random;
      int unsigned choice;
      via_op_type  op;
      logic [3:0]  addr;
      logic [7:0]  data;
      choice = $urandom_range(0, 99);
      addr = 4'($urandom_range(0, 15));
      data = 8'($urandom);
      if (choice < 40) op = OP_TICK;
      else if (choice < 70) op = OP_WRITE;
      else if (choice < 95) op = OP_READ;
      else op = OP_NONE;
      if (op == OP_WRITE && $urandom_range(0, 3) != 0) begin
         case (via_reg_type'(addr))
            REG_T1CL, REG_T1LL, REG_T2CL: data = 8'($urandom_range(0, 6));
            REG_T1CH, REG_T1LH, REG_T2CH: data = 8'h00;
            default: ;
         endcase
      end
      send_plain(op, addr, data);
   endtask

   // directed table, then random requests and short setup sequences
   initial begin : request_drive
      int unsigned choice;
      logic [7:0]  acr_val;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_READ;
      row_typed  <= 1'b0;
      row_rd     <= 8'h00;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                      directed_rows[i].cmp, directed_rows[i].alt, directed_rows[i].typed,
                      directed_rows[i].rd);

      while (items_sent < NUM_ITEMS) begin
         no_idle = (items_sent >= 250 && items_sent < 500);
         if (items_sent >= 700) hold_started = 1'b1;
         choice = $urandom_range(0, 99);
         if (choice < 8) begin
            // timer 1 start and run out
            send_plain(OP_WRITE, REG_T1LL, 8'($urandom_range(0, 6)));
            send_plain(OP_WRITE, REG_T1CH, 8'h00);
            send_ticks($urandom_range(2, 18));
         end else if (choice < 14) begin
            // timer 2 start and run out
            send_plain(OP_WRITE, REG_T2CL, 8'($urandom_range(0, 6)));
            send_plain(OP_WRITE, REG_T2CH, 8'h00);
            send_ticks($urandom_range(2, 9));
         end else if (choice < 20) begin
            // shift mode, divider, data, then a run of ticks
            acr_val = 8'($urandom);
            send_plain(OP_WRITE, REG_ACR, acr_val);
            send_plain(OP_WRITE, REG_T2CL, 8'($urandom_range(0, 3)));
            send_plain(OP_WRITE, REG_SR, 8'($urandom));
            send_ticks($urandom_range(8, 30));
            if ($urandom_range(0, 1) != 0) send_plain(OP_READ, REG_SR, 8'($urandom));
         end else begin
            send_random();
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS versatile_interface_adapter_top");
      else
         $display("FAIL versatile_interface_adapter_top");
      $finish;
   end

   // response side: random stalls, one long hold-off
   initial begin : response_drive
      int hold_count;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_started && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            hold_count = 0;
            while (hold_count < HOLD_CYCLES) begin
               @(negedge clock);
               hold_count++;
            end
         end else begin
            rsp_tready <= no_idle || ($urandom_range(0, 99) >= 14);
         end
      end
   end

   // predict on accepted requests, compare accepted responses
   always @(posedge clock) begin : scoreboard
      via_rsp_type expected;
      if (!reset && req_tvalid && req_tready) begin
         adapter_step(via_op_type'(req_tuser), req_tdata[3:0], req_tdata[11:4],
                      req_tdata[12], req_tdata[20:13], expected);
         if (row_typed) expected.read_data = row_rd;
         rsp_expected.push_back(expected);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_expected.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %08h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else begin
            expected = rsp_expected.pop_front();
            check_field("read_data", expected.read_data, rsp_tdata[7:0]);
            check_field("irq", {7'd0, expected.irq}, {7'd0, rsp_tdata[8]});
            check_field("port_a_out", expected.port_a_out, rsp_tdata[16:9]);
            check_field("port_b_out", expected.port_b_out, rsp_tdata[24:17]);
            check_field("ca2_level", {7'd0, expected.ca2_level}, {7'd0, rsp_tdata[25]});
            check_field("cb2_handshake", {7'd0, expected.cb2_handshake},
                        {7'd0, rsp_tdata[26]});
            check_field("cb2_shift", {7'd0, expected.cb2_shift}, {7'd0, rsp_tdata[27]});
            check_field("pb7_timer", {7'd0, expected.pb7_timer}, {7'd0, rsp_tdata[28]});
            check_field("padding", 8'h00, {5'b00000, rsp_tdata[31:29]});
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL versatile_interface_adapter_top");
         $finish;
      end
   end

endmodule
